// File: rtl/assert_macros.svh
// Assertion macros shared by the raster operations RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds -> cons holds in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante holds -> cons holds in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// expr never holds
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

// File: rtl/frop_pkg.sv
// Shared types, constants and codes for the fragment raster operations block.
// Depends on nothing; imported by every module of the block.
package frop_pkg;

  localparam int FRAME_WIDTH_DEF     = 512;
  localparam int FRAME_HEIGHT_DEF    = 512;
  localparam int DEPTH_TOLERANCE_DEF = 4;

  localparam int ADDR_W      = 20;
  localparam int QUEUE_DEPTH = 4;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 10;

  localparam logic signed [24:0] DEPTH_ONE = 25'sd4194304;
  localparam logic signed [24:0] DEPTH_NEG = -25'sd4194304;

  localparam logic [CFG_INDEX_W-1:0] REG_VIEWPORT_X      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_VIEWPORT_Y      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_VIEWPORT_WIDTH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_VIEWPORT_HEIGHT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_TEST_EN   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BLEND_EN        = 3'd5;

  localparam logic [OUT_TUSER_W-1:0] OUTCOME_WRITTEN    = 2'd0;
  localparam logic [OUT_TUSER_W-1:0] OUTCOME_CLIPPED    = 2'd1;
  localparam logic [OUT_TUSER_W-1:0] OUTCOME_DEPTH_FAIL = 2'd2;

  typedef struct packed {
    logic [8:0] vp_x;
    logic [8:0] vp_y;
    logic [9:0] vp_width;
    logic [9:0] vp_height;
  } view_cfg_t;

  typedef struct packed {
    logic depth_test_en;
    logic blend_en;
  } mode_cfg_t;

  typedef struct packed {
    logic               clipped;
    logic [ADDR_W-1:0]  addr;
    logic signed [23:0] depth;
    logic [3:0][7:0]    color;
  } frag_item_t;

endpackage

// File: rtl/frop_front.sv
// Front end: input register, viewport/frame/depth-range classification and
// pixel address. Depends on frop_pkg; feeds frop_fifo.
module frop_front #(
  parameter int FRAME_WIDTH  = frop_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = frop_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            hold,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [frop_pkg::IN_TDATA_W-1:0] s_tdata,
  input  frop_pkg::view_cfg_t             view,
  input  logic                            q_full,
  output logic                            q_push,
  output frop_pkg::frag_item_t            q_item
);
  import frop_pkg::*;

  localparam logic signed [12:0] X_LIM = 13'(FRAME_WIDTH);
  localparam logic signed [12:0] Y_LIM = 13'(FRAME_HEIGHT);
  localparam logic [ADDR_W-1:0]  ROW_PITCH = ADDR_W'(FRAME_WIDTH);

  logic                f_valid;
  logic signed [10:0]  f_x;
  logic signed [10:0]  f_y;
  logic signed [24:0]  f_depth;
  logic [3:0][7:0]     f_color;
  logic                in_xfer;

  logic signed [12:0]  x_ext;
  logic signed [12:0]  y_ext;
  logic [10:0]         x_end;
  logic [10:0]         y_end;
  logic                out_x;
  logic                out_y;
  logic                depth_bad;
  logic                clip;
  logic [ADDR_W-1:0]   addr_raw;

  assign s_tready = !hold && (!f_valid || !q_full);
  assign in_xfer  = s_tvalid && s_tready;
  assign q_push   = f_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_xfer) begin
      f_valid <= 1'b1;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      f_x     <= s_tdata[10:0];
      f_y     <= s_tdata[21:11];
      f_depth <= s_tdata[46:22];
      f_color <= s_tdata[78:47];
    end
  end

  always_comb begin
    x_ext = $signed({{2{f_x[10]}}, f_x});
    y_ext = $signed({{2{f_y[10]}}, f_y});
    x_end = 11'(view.vp_x) + 11'(view.vp_width);
    y_end = 11'(view.vp_y) + 11'(view.vp_height);
    out_x = (x_ext < $signed({4'b0, view.vp_x})) || (x_ext >= $signed({2'b0, x_end}))
            || f_x[10] || (x_ext >= X_LIM);
    out_y = (y_ext < $signed({4'b0, view.vp_y})) || (y_ext >= $signed({2'b0, y_end}))
            || f_y[10] || (y_ext >= Y_LIM);
    depth_bad = (f_depth > DEPTH_ONE) || (f_depth < DEPTH_NEG);
    clip      = out_x || out_y || depth_bad;
    addr_raw  = ADDR_W'(f_y[9:0]) * ROW_PITCH + ADDR_W'(f_x[9:0]);

    q_item.clipped = clip;
    q_item.addr    = clip ? '0 : addr_raw;
    q_item.depth   = f_depth[23:0];
    q_item.color   = f_color;
  end

endmodule

// File: rtl/frop_fifo.sv
// Short queue of classified fragments between front end and back end.
// Depends on frop_pkg.
`include "assert_macros.svh"

module frop_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  frop_pkg::frag_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output frop_pkg::frag_item_t head_item
);
  import frop_pkg::*;

  localparam int QA = $clog2(QUEUE_DEPTH);

  frag_item_t     slots [QUEUE_DEPTH];
  logic [QA-1:0]  wr_ptr;
  logic [QA-1:0]  rd_ptr;
  logic [QA:0]    count;

  assign head_valid = (count != '0);
  assign full       = (count == (QA+1)'(QUEUE_DEPTH));
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QA'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QA'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (QA+1)'(1);
        2'b01:   count <= count - (QA+1)'(1);
        default: count <= count;
      endcase
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst, push && full && !pop, "push into full queue")
  `ASSERT_NEVER(a_no_underflow, clk, rst, pop && !head_valid, "pop from empty queue")

endmodule

// File: rtl/frop_back.sv
// Back end: frame stores with clearing pass, read stage with write forwarding,
// depth test, blend multiply stage with divide, output register. Depends on frop_pkg.
`include "assert_macros.svh"

module frop_back #(
  parameter int FRAME_WIDTH     = frop_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT    = frop_pkg::FRAME_HEIGHT_DEF,
  parameter int DEPTH_TOLERANCE = frop_pkg::DEPTH_TOLERANCE_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  frop_pkg::mode_cfg_t              mode,
  output logic                             clearing,
  input  logic                             q_valid,
  input  frop_pkg::frag_item_t             q_item,
  output logic                             q_pop,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [frop_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic [frop_pkg::OUT_TUSER_W-1:0] m_tuser
);
  import frop_pkg::*;

  localparam int PIX    = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int PIX_AW = $clog2(PIX);
  localparam logic [PIX_AW-1:0] LAST_PIX  = PIX_AW'(PIX - 1);
  localparam logic signed [25:0] TOL      = 26'(DEPTH_TOLERANCE);
  localparam logic [23:0]        DEPTH_FAR = DEPTH_ONE[23:0];

  logic [3:0][7:0]    color_mem [PIX];
  logic [23:0]        depth_mem [PIX];

  logic [PIX_AW-1:0]  clr_addr;

  logic               s1_valid;
  frag_item_t         s1_item;
  logic [3:0][7:0]    rd_color;
  logic [23:0]        rd_depth;
  logic               fw_valid;
  logic [3:0][7:0]    fw_color;
  logic [23:0]        fw_depth;

  logic               s2_valid;
  logic               s2_clipped;
  logic               s2_fail;
  logic [PIX_AW-1:0]  s2_addr;
  logic [23:0]        s2_depth;
  logic [3:0][7:0]    s2_src;
  logic [3:0][15:0]   s2_psrc;
  logic [3:0][15:0]   s2_pdst;

  logic                   out_valid;
  logic [OUT_TUSER_W-1:0] out_outcome;
  logic [3:0][7:0]        out_color;

  logic [PIX_AW-1:0]  q_addr;
  logic [PIX_AW-1:0]  s1_addr;
  logic [3:0][7:0]    dst_color;
  logic [23:0]        dst_depth;
  logic signed [25:0] frag_less_tol;
  logic signed [25:0] dst_ext;
  logic               s1_fail;
  logic [7:0]         inv_alpha;
  logic [3:0][15:0]   psrc;
  logic [3:0][15:0]   pdst;

  logic [3:0][7:0]    res;
  logic [OUT_TUSER_W-1:0] s2_outcome;
  logic               s2_writes;

  logic               out_free;
  logic               s2_adv;
  logic               hazard;
  logic               s1_adv;
  logic               s1_load;
  logic               item_we;
  logic               mem_we;
  logic [PIX_AW-1:0]  mem_waddr;
  logic [3:0][7:0]    mem_wcolor;
  logic [23:0]        mem_wdepth;

  assign q_addr  = q_item.addr[PIX_AW-1:0];
  assign s1_addr = s1_item.addr[PIX_AW-1:0];

  // pipeline control
  assign out_free = !out_valid || m_tready;
  assign s2_adv   = s2_valid && out_free;
  assign hazard   = s2_valid && s2_writes && !s1_item.clipped && (s2_addr == s1_addr);
  assign s1_adv   = s1_valid && (!s2_valid || s2_adv) && !hazard;
  assign s1_load  = q_valid && (!s1_valid || s1_adv);
  assign q_pop    = s1_load;

  // store clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST_PIX) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + PIX_AW'(1);
      end
    end
  end

  assign item_we    = s2_adv && s2_writes;
  assign mem_we     = clearing || item_we;
  assign mem_waddr  = clearing ? clr_addr : s2_addr;
  assign mem_wcolor = clearing ? '0 : res;
  assign mem_wdepth = clearing ? DEPTH_FAR : s2_depth;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      color_mem[mem_waddr] <= mem_wcolor;
      depth_mem[mem_waddr] <= mem_wdepth;
    end
    if (s1_load) begin
      rd_color <= color_mem[q_addr];
      rd_depth <= depth_mem[q_addr];
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fw_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= 1'b1;
        fw_valid <= item_we && (s2_addr == q_addr);
      end else begin
        if (s1_adv) begin
          s1_valid <= 1'b0;
        end
        if (item_we && (s2_addr == s1_addr)) begin
          fw_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item <= q_item;
    end
    if (item_we && ((s1_load && (s2_addr == q_addr)) || (!s1_load && (s2_addr == s1_addr)))) begin
      fw_color <= res;
      fw_depth <= s2_depth;
    end
  end

  always_comb begin
    dst_color     = fw_valid ? fw_color : rd_color;
    dst_depth     = fw_valid ? fw_depth : rd_depth;
    frag_less_tol = $signed({{2{s1_item.depth[23]}}, s1_item.depth}) - TOL;
    dst_ext       = $signed({{2{dst_depth[23]}}, dst_depth});
    s1_fail       = mode.depth_test_en && (frag_less_tol > dst_ext);
    inv_alpha     = 8'd255 - s1_item.color[3];
    for (int c = 0; c < 4; c++) begin
      psrc[c] = 16'(s1_item.color[3]) * 16'(s1_item.color[c]);
      pdst[c] = 16'(inv_alpha) * 16'(dst_color[c]);
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_clipped <= s1_item.clipped;
      s2_fail    <= s1_fail;
      s2_addr    <= s1_addr;
      s2_depth   <= s1_item.depth;
      s2_src     <= s1_item.color;
      s2_psrc    <= psrc;
      s2_pdst    <= pdst;
    end
  end

  // divide by 255: (s + 1 + (s >> 8)) >> 8, exact for s up to 65534
  always_comb begin
    logic [16:0] sum;
    logic [16:0] quot;
    for (int c = 0; c < 4; c++) begin
      sum    = 17'(s2_psrc[c]) + 17'(s2_pdst[c]) + 17'd127;
      quot   = sum + 17'd1 + (sum >> 8);
      res[c] = mode.blend_en ? quot[15:8] : s2_src[c];
    end
  end

  assign s2_writes = !s2_clipped && !s2_fail;

  always_comb begin
    priority if (s2_clipped) begin
      s2_outcome = OUTCOME_CLIPPED;
    end else if (s2_fail) begin
      s2_outcome = OUTCOME_DEPTH_FAIL;
    end else begin
      s2_outcome = OUTCOME_WRITTEN;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_outcome <= s2_outcome;
      out_color   <= s2_writes ? res : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_color;
  assign m_tuser  = out_outcome;

  `ASSERT_NEVER(a_clear_idle, clk, rst, clearing && (s1_valid || s2_valid || out_valid), "item in flight during store clear")
  `ASSERT_NEXT(a_fwd_capture, clk, rst, s1_valid && !s1_adv && item_we && (mem_waddr == s1_addr), fw_valid, "write to held pixel not forwarded")
  `ASSERT_IMPLIES(a_blank_color, clk, rst, out_valid && (out_outcome != OUTCOME_WRITTEN), out_color == '0, "color on a fragment that was not written")

endmodule

// File: rtl/fragment_raster_ops_core.sv
// Channel   Dir  Handshake            Payload (low bit first)
// cfg       in   cfg_wr_en            cfg_index, cfg_wr_data
// s         in   s_tvalid / s_tready  x, y, depth, red, green, blue, alpha
// m         out  m_tvalid / m_tready  tuser: outcome; tdata: red, green, blue, alpha
//
// One fragment per cycle while the output is not held; a fragment that hits the
// same pixel as a written fragment directly ahead of it waits at the store read
// stage until that fragment has left the multiply stage. A fragment passes the
// input register, queue, read stage, multiply stage and output register. After
// reset a clearing pass writes each of the FRAME_WIDTH*FRAME_HEIGHT store
// entries (262144 by default); s_tready stays low during it. m_tready low holds
// the output register; the four-entry queue then fills and s_tready drops.
// Top level: configuration registers and wiring of front end, queue and back end.
// Depends on frop_pkg, frop_front, frop_fifo, frop_back.
module fragment_raster_ops_core #(
  parameter int FRAME_WIDTH     = frop_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT    = frop_pkg::FRAME_HEIGHT_DEF,
  parameter int DEPTH_TOLERANCE = frop_pkg::DEPTH_TOLERANCE_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [frop_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [frop_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // pixel_x, pixel_y, frag_depth, src_red, src_green, src_blue, src_alpha, pad
  input  logic [frop_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [frop_pkg::OUT_TDATA_W-1:0] m_tdata,
  // outcome
  output logic [frop_pkg::OUT_TUSER_W-1:0] m_tuser
);
  import frop_pkg::*;

  view_cfg_t  view;
  mode_cfg_t  mode;
  logic       clearing;
  logic       q_full;
  logic       q_push;
  frag_item_t push_item;
  logic       q_valid;
  logic       q_pop;
  frag_item_t head_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      view.vp_x          <= '0;
      view.vp_y          <= '0;
      view.vp_width      <= 10'd512;
      view.vp_height     <= 10'd512;
      mode.depth_test_en <= 1'b0;
      mode.blend_en      <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_VIEWPORT_X:      view.vp_x          <= cfg_wr_data[8:0];
        REG_VIEWPORT_Y:      view.vp_y          <= cfg_wr_data[8:0];
        REG_VIEWPORT_WIDTH:  view.vp_width      <= cfg_wr_data[9:0];
        REG_VIEWPORT_HEIGHT: view.vp_height     <= cfg_wr_data[9:0];
        REG_DEPTH_TEST_EN:   mode.depth_test_en <= cfg_wr_data[0];
        REG_BLEND_EN:        mode.blend_en      <= cfg_wr_data[0];
        default: begin
        end
      endcase
    end
  end

  frop_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .hold     (clearing),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .view     (view),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  frop_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (head_item)
  );

  frop_back #(
    .FRAME_WIDTH     (FRAME_WIDTH),
    .FRAME_HEIGHT    (FRAME_HEIGHT),
    .DEPTH_TOLERANCE (DEPTH_TOLERANCE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .mode     (mode),
    .clearing (clearing),
    .q_valid  (q_valid),
    .q_item   (head_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// File: test/fragment_raster_ops_core_tb.sv
// Self-checking testbench for fragment_raster_ops_core: viewport and depth-range
// clipping, depth test with tolerance, source-alpha blending into the frame stores.
// Depends on frop_pkg and the fragment_raster_ops_core RTL.
module fragment_raster_ops_core_tb;
  import frop_pkg::*;

  localparam int DEPTH_UNIT  = DEPTH_ONE;
  localparam int VP_SIZE_RST = 512;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 60;
  localparam logic [CFG_INDEX_W-1:0] REG_ORDER [6] = '{REG_VIEWPORT_X, REG_VIEWPORT_Y,
    REG_VIEWPORT_WIDTH, REG_VIEWPORT_HEIGHT, REG_DEPTH_TEST_EN, REG_BLEND_EN};

  typedef struct packed {
    logic [OUT_TUSER_W-1:0] outcome;
    logic [OUT_TDATA_W-1:0] color;
  } frag_result_t;

  class frag_scoreboard;
    int vp_x, vp_y, vp_w, vp_h;
    bit depth_test_en, blend_en;
    bit [31:0] color_mem [int];
    int depth_mem [int];
    frag_result_t expected_q [$];
    string chan_name [4] = '{"red", "green", "blue", "alpha"};
    int errors, n_frags, n_written, n_clipped, n_depth_fail;

    function new();
      vp_x = 0;
      vp_y = 0;
      vp_w = VP_SIZE_RST;
      vp_h = VP_SIZE_RST;
      depth_test_en = 1'b0;
      blend_en = 1'b0;
      errors = 0;
      n_frags = 0;
      n_written = 0;
      n_clipped = 0;
      n_depth_fail = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, int value);
      case (idx)
        REG_VIEWPORT_X:      vp_x = value & 'h1FF;
        REG_VIEWPORT_Y:      vp_y = value & 'h1FF;
        REG_VIEWPORT_WIDTH:  vp_w = value & 'h3FF;
        REG_VIEWPORT_HEIGHT: vp_h = value & 'h3FF;
        REG_DEPTH_TEST_EN:   depth_test_en = value[0];
        REG_BLEND_EN:        blend_en = value[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_fragment(logic [IN_TDATA_W-1:0] frag);
      logic signed [10:0] sx, sy;
      logic signed [24:0] sd;
      int x, y, d, addr, stored, a, src, c;
      bit [31:0] dst, res;
      frag_result_t exp_res;
      sx = frag[10:0];
      sy = frag[21:11];
      sd = frag[46:22];
      x = int'(sx);
      y = int'(sy);
      d = int'(sd);
      a = int'(frag[78:71]);
      n_frags++;
      exp_res.outcome = OUTCOME_WRITTEN;
      exp_res.color = '0;
      if (x < vp_x || x >= vp_x + vp_w || y < vp_y || y >= vp_y + vp_h
          || d > DEPTH_UNIT || d < -DEPTH_UNIT
          || x < 0 || y < 0 || x >= FRAME_WIDTH_DEF || y >= FRAME_HEIGHT_DEF) begin
        exp_res.outcome = OUTCOME_CLIPPED;
        n_clipped++;
      end else begin
        addr = y * FRAME_WIDTH_DEF + x;
        stored = depth_mem.exists(addr) ? depth_mem[addr] : DEPTH_UNIT;
        if (depth_test_en && d - DEPTH_TOLERANCE_DEF > stored) begin
          exp_res.outcome = OUTCOME_DEPTH_FAIL;
          n_depth_fail++;
        end else begin
          dst = color_mem.exists(addr) ? color_mem[addr] : '0;
          for (c = 0; c < 4; c++) begin
            src = int'(frag[47 + 8*c +: 8]);
            if (blend_en)
              res[8*c +: 8] = 8'((a * src + (255 - a) * int'(dst[8*c +: 8]) + 127) / 255);
            else
              res[8*c +: 8] = 8'(src);
          end
          color_mem[addr] = res;
          depth_mem[addr] = d;
          exp_res.color = res;
          n_written++;
        end
      end
      expected_q.push_back(exp_res);
    endfunction

    function void check_result(logic [OUT_TUSER_W-1:0] outcome,
                               logic [OUT_TDATA_W-1:0] color);
      frag_result_t exp_res;
      int c;
      if (expected_q.size() == 0) begin
        $display("%0t: result with none expected: expected nothing, actual outcome %0d color %h",
                 $time, outcome, color);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (outcome !== exp_res.outcome) begin
        $display("%0t: outcome expected %0d actual %0d", $time, exp_res.outcome, outcome);
        errors++;
      end
      for (c = 0; c < 4; c++)
        if (color[8*c +: 8] !== exp_res.color[8*c +: 8]) begin
          $display("%0t: %s expected %0d actual %0d", $time, chan_name[c],
                   exp_res.color[8*c +: 8], color[8*c +: 8]);
          errors++;
        end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;

  frag_scoreboard sb;
  int  send_idle = 0;
  int  recv_stall = 0;
  logic hold_go = 1'b0;
  int  hold_cnt = 0;
  int  cycle_cnt = 0;
  int  cur_vx, cur_vy, cur_vw, cur_vh;
  int  x_lo, x_hi, y_lo, y_hi;
  bit  area_ok;
  int  pool_x [4];
  int  pool_y [4];
  int  last_x, last_y, last_d;
  bit  have_last = 1'b0;
  int  ph;

  fragment_raster_ops_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_cnt != 0)
      hold_cnt <= hold_cnt - 1;
    else if (hold_go)
      hold_cnt <= HOLD_CYCLES;
    m_tready <= (hold_cnt == 0) && !hold_go && ($urandom_range(0, 99) >= recv_stall);
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tuser, m_tdata);

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic load_config(input int vx, vy, vw, vh, dt, bl);
    int vals [6];
    int i;
    vals = '{vx, vy, vw, vh, dt, bl};
    for (i = 0; i < 6; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_wr_data <= vals[i][CFG_DATA_W-1:0];
      @(posedge clk);
      sb.set_reg(REG_ORDER[i], vals[i]);
    end
    cfg_wr_en <= 1'b0;
    cur_vx = vx;
    cur_vy = vy;
    cur_vw = vw;
    cur_vh = vh;
    x_lo = vx;
    y_lo = vy;
    x_hi = ((vx + vw < FRAME_WIDTH_DEF) ? vx + vw : FRAME_WIDTH_DEF) - 1;
    y_hi = ((vy + vh < FRAME_HEIGHT_DEF) ? vy + vh : FRAME_HEIGHT_DEF) - 1;
    area_ok = (x_hi >= x_lo) && (y_hi >= y_lo);
    if (area_ok)
      for (i = 0; i < 4; i++) begin
        pool_x[i] = $urandom_range(x_lo, x_hi);
        pool_y[i] = $urandom_range(y_lo, y_hi);
      end
  endtask

  task automatic send_frag(input int x, y, d, input logic [7:0] r, g, b, a);
    int gap;
    logic [IN_TDATA_W-1:0] frag;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle)
      gap++;
    frag = {{(IN_TDATA_W-79){1'b0}}, a, b, g, r, d[24:0], y[10:0], x[10:0]};
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= frag;
    @(posedge clk);
    while (s_tready !== 1'b1)
      @(posedge clk);
    sb.note_fragment(frag);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
  endtask

  task automatic random_frag();
    int kind, x, y, d, pick;
    logic [7:0] r, g, b, a;
    kind = $urandom_range(0, 99);
    r = 8'($urandom_range(0, 255));
    g = 8'($urandom_range(0, 255));
    b = 8'($urandom_range(0, 255));
    a = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0)
      a = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
    if (kind < 70 && area_ok) begin
      if (kind < 25 && have_last) begin
        x = last_x;
        y = last_y;
        d = last_d + int'($urandom_range(0, 10)) - 5;
      end else begin
        if (kind < 50) begin
          pick = $urandom_range(0, 3);
          x = pool_x[pick];
          y = pool_y[pick];
        end else begin
          x = $urandom_range(x_lo, x_hi);
          y = $urandom_range(y_lo, y_hi);
        end
        d = int'($urandom_range(0, 2 * DEPTH_UNIT)) - DEPTH_UNIT;
      end
    end else if (kind < 85) begin
      case ($urandom_range(0, 3))
        0:       x = cur_vx - 1;
        1:       x = cur_vx;
        2:       x = cur_vx + cur_vw - 1;
        default: x = cur_vx + cur_vw;
      endcase
      case ($urandom_range(0, 3))
        0:       y = cur_vy - 1;
        1:       y = cur_vy;
        2:       y = cur_vy + cur_vh - 1;
        default: y = cur_vy + cur_vh;
      endcase
      case ($urandom_range(0, 4))
        0:       d = DEPTH_UNIT;
        1:       d = -DEPTH_UNIT;
        2:       d = DEPTH_UNIT + 1;
        3:       d = -DEPTH_UNIT - 1;
        default: d = int'($urandom_range(0, 2 * DEPTH_UNIT)) - DEPTH_UNIT;
      endcase
    end else begin
      x = int'($urandom_range(0, 2047)) - 1024;
      y = int'($urandom_range(0, 2047)) - 1024;
      d = int'($urandom_range(0, 33554431)) - 16777216;
    end
    last_x = x;
    last_y = y;
    last_d = d;
    have_last = 1'b1;
    send_frag(x, y, d, r, g, b, a);
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    load_config(8, 4, 100, 50, 1, 1);
    send_frag(7, 10, 0, 8'd10, 8'd20, 8'd30, 8'd40);
    send_frag(8, 10, 0, 8'd255, 8'd0, 8'd128, 8'd255);
    send_frag(107, 53, 0, 8'd1, 8'd2, 8'd3, 8'd200);
    send_frag(108, 10, 0, 8'd10, 8'd20, 8'd30, 8'd40);
    send_frag(20, 3, 0, 8'd10, 8'd20, 8'd30, 8'd40);
    send_frag(20, 4, 0, 8'd10, 8'd20, 8'd30, 8'd40);
    send_frag(20, 54, 0, 8'd10, 8'd20, 8'd30, 8'd40);
    send_frag(30, 20, DEPTH_UNIT, 8'd255, 8'd255, 8'd255, 8'd255);
    send_frag(31, 20, -DEPTH_UNIT, 8'd0, 8'd0, 8'd0, 8'd0);
    send_frag(32, 20, DEPTH_UNIT + 1, 8'd10, 8'd20, 8'd30, 8'd40);
    send_frag(32, 20, -DEPTH_UNIT - 1, 8'd10, 8'd20, 8'd30, 8'd40);
    send_frag(-1024, -1024, -16777216, 8'd10, 8'd20, 8'd30, 8'd40);
    send_frag(1023, 1023, 16777215, 8'd10, 8'd20, 8'd30, 8'd40);
    send_frag(40, 30, 0, 8'd200, 8'd100, 8'd50, 8'd128);
    send_frag(40, 30, 4, 8'd17, 8'd99, 8'd250, 8'd77);
    send_frag(40, 30, 9, 8'd10, 8'd20, 8'd30, 8'd40);
    send_frag(40, 30, 8, 8'd255, 8'd255, 8'd255, 8'd0);
    send_frag(40, 30, -DEPTH_UNIT, 8'd255, 8'd255, 8'd255, 8'd255);
    drain();
    load_config(500, 500, 512, 512, 0, 0);
    send_frag(512, 505, 0, 8'd10, 8'd20, 8'd30, 8'd40);
    send_frag(505, 512, 0, 8'd10, 8'd20, 8'd30, 8'd40);
    send_frag(511, 511, 0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_frag(499, 505, 0, 8'd10, 8'd20, 8'd30, 8'd40);
    drain();
    load_config(0, 0, 0, 0, 0, 1);
    send_frag(0, 0, 0, 8'd10, 8'd20, 8'd30, 8'd40);
    drain();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: load_config(0, 0, 512, 512, 0, 0);
        1: load_config(0, 0, 512, 512, 1, 1);
        2: load_config(511, 511, 512, 512, 1, 1);
        3: load_config(0, 0, 0, 0, 1, 0);
        4: load_config(0, 0, 16, 16, 1, 1);
        5: load_config($urandom_range(0, 479), $urandom_range(0, 479),
                       $urandom_range(1, 32), $urandom_range(1, 32), 1, 1);
        6: load_config($urandom_range(0, 511), $urandom_range(0, 511),
                       $urandom_range(0, 512), $urandom_range(0, 512),
                       $urandom_range(0, 1), $urandom_range(0, 1));
        default: load_config(300, 200, 512, 512, 0, 1);
      endcase
      case (ph % 4)
        0: begin
          send_idle = 0;
          recv_stall <= 0;
        end
        1: begin
          send_idle = 63;
          recv_stall <= 0;
        end
        2: begin
          send_idle = 0;
          recv_stall <= 63;
        end
        default: begin
          send_idle = 8;
          recv_stall <= 8;
        end
      endcase
      if (ph == 0) begin
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      repeat (PHASE_ITEMS) random_frag();
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Covered %0d fragments over %0d register settings, incl. a long output stall:",
             sb.n_frags, PHASES + 3);
    $display("  %0d written, %0d clipped, %0d failed the depth test",
             sb.n_written, sb.n_clipped, sb.n_depth_fail);
    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
